### design/kss_pkg.sv
package kss_pkg;

   localparam int RegWidth           = 11;
   localparam int ValWidth           = 32;
   localparam int BitIdxWidth        = $clog2(ValWidth);
   localparam int DefaultMaxElements = 1024;

   localparam logic [ValWidth-1:0] SignFlip = {1'b1, {(ValWidth-1){1'b0}}};

   // register map
   localparam int CsrIdxWidth = 2;
   localparam logic [CsrIdxWidth-1:0] CSR_RANGE_FIRST = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_RANGE_LAST  = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_RANK_K      = 2'd2;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef struct packed {
      logic store;    // write accepted sample into the store
      logic check;    // validate range and rank, set up first pass
      logic scan;     // read one store entry
      logic decide;   // settle one key bit, set up next pass
      logic emit;     // load result register, restart sequence
   } kss_cmd_type;

   typedef struct packed {
      logic err;
      logic scan_end;
      logic last_bit;
      logic out_free;
   } kss_sts_type;

endpackage

### design/kss_req_if.sv
interface kss_req_if import kss_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [ValWidth-1:0] sample_value;
   logic                       final_element;

   modport source (output valid, output sample_value, output final_element, input ready);
   modport sink   (input valid, input sample_value, input final_element, output ready);
endinterface

### design/kss_rsp_if.sv
interface kss_rsp_if import kss_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [ValWidth-1:0] kth_value;
   logic                       status;

   modport source (output valid, output kth_value, output status, input ready);
   modport sink   (input valid, input kth_value, input status, output ready);
endinterface

### design/range_kth_smallest_select_top.sv
// Range k-th smallest select. Requests load signed 32-bit samples into a store, one per
// cycle, positions 1, 2, ... in order; a request with final_element set closes the sequence.
// The block then reports the rank_k-th smallest stored value among positions
// range_first..range_last (duplicates counted) with status 0, or value 0 with status 1
// when range_first is 0, the range is empty, runs past the loaded count, or rank_k is 0
// or exceeds the range length. Samples beyond MaxElements are dropped. Selection is a
// bitwise radix search over the single-port store: 32 passes, each reading every entry
// of the range (none on an error), before the result is registered; no request is taken
// meanwhile. The store needs no clearing after reset. csr_* writes are to be issued only
// while the block is idle.
module range_kth_smallest_select_top import kss_pkg::*; #(
   parameter int MaxElements = DefaultMaxElements
) (
   input  logic                   clock,
   input  logic                   reset,
   kss_req_if.sink                req_bus,
   kss_rsp_if.source              rsp_bus,
   input  logic                   csr_wr_en,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [RegWidth-1:0]    csr_wdata
);

   logic [RegWidth-1:0] range_first, range_last, rank_k;
   kss_cmd_type         cmd;
   kss_sts_type         sts;

   kss_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .range_first (range_first),
      .range_last  (range_last),
      .rank_k      (rank_k)
   );

   kss_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_bus.valid),
      .req_final_element (req_bus.final_element),
      .req_ready         (req_bus.ready),
      .sts               (sts),
      .cmd               (cmd)
   );

   kss_dp #(.MaxElements(MaxElements)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_sample_value (req_bus.sample_value),
      .range_first      (range_first),
      .range_last       (range_last),
      .rank_k           (rank_k),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_kth_value    (rsp_bus.kth_value),
      .rsp_status       (rsp_bus.status)
   );

endmodule

### design/kss_csr.sv
module kss_csr import kss_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [RegWidth-1:0]    csr_wdata,
   output logic [RegWidth-1:0]    range_first,
   output logic [RegWidth-1:0]    range_last,
   output logic [RegWidth-1:0]    rank_k
);

   logic [RegWidth-1:0] first_ff, last_ff, rank_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= RegWidth'(1);
         last_ff  <= RegWidth'(1);
         rank_ff  <= RegWidth'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_RANGE_FIRST: first_ff <= csr_wdata;
            CSR_RANGE_LAST:  last_ff  <= csr_wdata;
            CSR_RANK_K:      rank_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign range_first = first_ff;
   assign range_last  = last_ff;
   assign rank_k      = rank_ff;

endmodule

### design/kss_ctrl.sv
module kss_ctrl import kss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_final_element,
   output logic        req_ready,
   input  kss_sts_type sts,
   output kss_cmd_type cmd
);

   localparam logic [2:0] S_LOAD   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_DRAIN  = 3'd3;
   localparam logic [2:0] S_DECIDE = 3'd4;
   localparam logic [2:0] S_EMIT   = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            cmd.store = req_valid;
            if (req_valid && req_final_element) state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = sts.err ? S_EMIT : S_SCAN;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_end) state_in = S_DRAIN;
         end
         // last read of the pass still in flight
         S_DRAIN: state_in = S_DECIDE;
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = sts.last_bit ? S_EMIT : S_SCAN;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_LOAD;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_LOAD;
      else       state_ff <= state_in;
   end

endmodule

### design/kss_dp.sv
module kss_dp import kss_pkg::*; #(
   parameter int MaxElements = DefaultMaxElements
) (
   input  logic                       clock,
   input  logic                       reset,
   input  kss_cmd_type                cmd,
   output kss_sts_type                sts,
   input  logic signed [ValWidth-1:0] req_sample_value,
   input  logic [RegWidth-1:0]        range_first,
   input  logic [RegWidth-1:0]        range_last,
   input  logic [RegWidth-1:0]        rank_k,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [ValWidth-1:0] rsp_kth_value,
   output logic                       rsp_status
);

   localparam int AW = $clog2(MaxElements);
   localparam int CW = $clog2(MaxElements + 1);
   localparam int VW = (AW > RegWidth) ? AW : RegWidth;
   localparam int KW = (CW > RegWidth) ? CW : RegWidth;

   logic [ValWidth-1:0] mem [MaxElements];

   logic [CW-1:0]          count_ff;
   logic [AW-1:0]          addr_ff;
   logic [ValWidth-1:0]    rd_data_ff;
   logic                   rd_vld_ff;
   logic [RegWidth-1:0]    cnt_ff;
   logic [RegWidth-1:0]    krem_ff;
   logic [ValWidth-1:0]    prefix_ff;
   logic [BitIdxWidth-1:0] bit_ff;
   logic                   err_ff;
   logic                   rsp_valid_ff;
   logic [ValWidth-1:0]    rsp_value_ff;
   logic                   rsp_status_ff;

   // range and rank checks
   logic [KW-1:0]       first_x, last_x, count_x;
   logic [RegWidth-1:0] range_len;
   logic                err;

   assign first_x   = KW'(range_first);
   assign last_x    = KW'(range_last);
   assign count_x   = KW'(count_ff);
   assign range_len = range_last - range_first + RegWidth'(1);
   assign err = (range_first == '0) || (last_x < first_x) || (last_x > count_x) ||
                (rank_k == '0) || (rank_k > range_len);

   logic [VW-1:0] first_v, last_v;
   logic [AW-1:0] start_addr, end_addr;

   assign first_v    = VW'(range_first) - VW'(1);
   assign last_v     = VW'(range_last) - VW'(1);
   assign start_addr = first_v[AW-1:0];
   assign end_addr   = last_v[AW-1:0];

   // radix select: count keys that share the settled high bits and have a 0 at bit_ff
   logic [ValWidth:0]   span;
   logic [ValWidth-1:0] hi_mask, key;
   logic                hit;

   assign span    = ((ValWidth+1)'(1) << ({1'b0, bit_ff} + 1'b1)) - (ValWidth+1)'(1);
   assign hi_mask = ~span[ValWidth-1:0];
   assign key     = rd_data_ff ^ SignFlip;
   assign hit     = rd_vld_ff && (((key ^ prefix_ff) & hi_mask) == '0) && !key[bit_ff];

   always_ff @(posedge clock) begin
      if (cmd.store && (count_ff < CW'(MaxElements)))
         mem[count_ff[AW-1:0]] <= req_sample_value;
      if (cmd.scan)
         rd_data_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.scan;
         if (cmd.emit)
            count_ff <= '0;
         else if (cmd.store && (count_ff < CW'(MaxElements)))
            count_ff <= count_ff + CW'(1);
         if (cmd.emit)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.check) begin
         err_ff    <= err;
         krem_ff   <= rank_k;
         prefix_ff <= '0;
         bit_ff    <= BitIdxWidth'(ValWidth - 1);
         addr_ff   <= start_addr;
         cnt_ff    <= '0;
      end else if (cmd.decide) begin
         if (krem_ff > cnt_ff) begin
            krem_ff   <= krem_ff - cnt_ff;
            prefix_ff <= prefix_ff | (ValWidth'(1) << bit_ff);
         end
         bit_ff  <= bit_ff - BitIdxWidth'(1);
         addr_ff <= start_addr;
         cnt_ff  <= '0;
      end else begin
         if (cmd.scan) addr_ff <= addr_ff + AW'(1);
         if (hit)      cnt_ff  <= cnt_ff + RegWidth'(1);
      end
      if (cmd.emit) begin
         rsp_value_ff  <= err_ff ? '0 : (prefix_ff ^ SignFlip);
         rsp_status_ff <= err_ff ? STATUS_ERR : STATUS_OK;
      end
   end

   assign sts.err      = err;
   assign sts.scan_end = (addr_ff == end_addr);
   assign sts.last_bit = (bit_ff == '0);
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kth_value = $signed(rsp_value_ff);
   assign rsp_status    = rsp_status_ff;

`ifndef SYNTHESIS
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_ERR) |-> rsp_value_ff == '0)
      else $error("error result carries nonzero value");
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MaxElements))
      else $error("loaded count above store depth");
   a_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.decide |-> !rd_vld_ff && !cmd.scan)
      else $error("bit decided with a read still in flight");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("result not presented after emit");
`endif

endmodule
